FILE: src/i2da_pkg.sv
`default_nettype none
package i2da_pkg;

	localparam int MAX_WIDTH  = 32;
	localparam int VALUE_BITS = 64;

	// decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
	localparam int NDIG     = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS = NDIG * 4;
	localparam int PAD_BITS = $clog2(MAX_WIDTH + 1);
	localparam int POS_BITS = $clog2(MAX_WIDTH);
	localparam int CNT_BITS = $clog2(VALUE_BITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		logic                  neg;
		logic [PAD_BITS-1:0]   padw;
	} job_t;

endpackage
`default_nettype wire

FILE: src/i2da_in_if.sv
`default_nettype none
interface i2da_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic        is_signed;
	logic [5:0]  min_width;

	modport source (output valid, output value, output is_signed, output min_width,
		input ready);
	modport sink (input valid, input value, input is_signed, input min_width,
		output ready);
endinterface
`default_nettype wire

FILE: src/i2da_out_if.sv
`default_nettype none
interface i2da_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

FILE: src/i2da_front.sv
`default_nettype none
module i2da_front (
	i2da_in_if.sink      din,
	output logic         job_valid,
	input  logic         job_ready,
	output i2da_pkg::job_t job
);
	import i2da_pkg::*;

	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [6:0]            wext;
	logic [PAD_BITS-1:0]   wclamp;

	always_comb begin
		raw  = din.value[VALUE_BITS-1:0];
		neg  = din.is_signed & raw[VALUE_BITS-1];
		wext = {1'b0, din.min_width};
		if (wext > 7'(MAX_WIDTH)) begin
			wclamp = PAD_BITS'(MAX_WIDTH);
		end else begin
			wclamp = PAD_BITS'(wext);
		end
		job.neg = neg;
		job.mag = neg ? (~raw + VALUE_BITS'(1)) : raw;
		// sign takes one place of the width
		if (neg && wclamp != '0) begin
			job.padw = wclamp - PAD_BITS'(1);
		end else begin
			job.padw = wclamp;
		end
	end

	assign job_valid = din.valid;
	assign din.ready = job_ready;

endmodule
`default_nettype wire

FILE: src/i2da_queue.sv
`default_nettype none
module i2da_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  i2da_pkg::job_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output i2da_pkg::job_t pop_data
);
	import i2da_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/i2da_back.sv
`default_nettype none
module i2da_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  i2da_pkg::job_t job,
	i2da_out_if.source     dout
);
	import i2da_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	function automatic logic [BCD_BITS-1:0] dabble(input logic [BCD_BITS-1:0] bcd,
		input logic b);
		logic [BCD_BITS-1:0] adj;
		adj = bcd;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end
		end
		return {adj[BCD_BITS-2:0], b};
	endfunction

	logic [1:0]            state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  neg_q;
	logic [PAD_BITS-1:0]   padw_q;
	logic [POS_BITS-1:0]   pos_q;
	logic                  started_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic                  out_free;
	logic                  in_dig;
	logic [3:0]            dig;
	logic                  skip;
	logic                  out_load;
	logic [7:0]            load_char;
	logic                  load_last;

	assign out_free  = !out_valid_q || dout.ready;
	assign job_ready = (state_q == ST_IDLE);
	assign in_dig    = pos_q < POS_BITS'(NDIG);
	assign dig       = in_dig ? bcd_q[BCD_BITS-1 -: 4] : 4'd0;
	// leading zero above the padded width
	assign skip      = !started_q && (pos_q != '0) && (dig == 4'd0)
		&& (PAD_BITS'(pos_q) >= padw_q);

	always_comb begin
		out_load  = 1'b0;
		load_char = CHAR_MINUS;
		load_last = 1'b0;
		if (state_q == ST_SIGN) begin
			out_load = out_free;
		end else if (state_q == ST_EMIT) begin
			out_load  = out_free && !skip;
			load_char = CHAR_ZERO + {4'd0, dig};
			load_last = (pos_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
		unique case (state_q)
			ST_IDLE: begin
				bin_q  <= job.mag;
				bcd_q  <= '0;
				neg_q  <= job.neg;
				padw_q <= job.padw;
				if (job.padw > PAD_BITS'(NDIG)) begin
					pos_q <= POS_BITS'(job.padw - PAD_BITS'(1));
				end else begin
					pos_q <= POS_BITS'(NDIG - 1);
				end
			end
			ST_CONV: begin
				bcd_q <= dabble(bcd_q, bin_q[VALUE_BITS-1]);
				bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			end
			ST_EMIT: begin
				if (out_free) begin
					pos_q <= pos_q - POS_BITS'(1);
					if (in_dig) begin
						bcd_q <= {bcd_q[BCD_BITS-5:0], 4'd0};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					started_q <= 1'b0;
					if (job_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(VALUE_BITS - 1)) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						started_q <= started_q | !skip;
						if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.character = out_char_q;
	assign dout.last      = out_last_q;

`ifndef ASSERT_OFF
	a_conv_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && cnt_q == CNT_BITS'(VALUE_BITS - 1)) |=> (state_q != ST_CONV))
		else $error("conversion overran");
	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && in_dig) |-> (bcd_q[BCD_BITS-1 -: 4] <= 4'd9))
		else $error("bad bcd digit");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && load_last) |=> (state_q == ST_IDLE))
		else $error("item did not end after last");
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> neg_q)
		else $error("sign for non-negative item");
`endif

endmodule
`default_nettype wire

FILE: src/integer_to_decimal_ascii_unit.sv
`default_nettype none
// Integer to zero-padded decimal ASCII. Each input item (value, is_signed,
// min_width) yields its text one character per output item, most significant
// first, '-' first for a negative value, last set on the final character.
// An item is loaded, converted by bit-serial binary-to-BCD shifting of all
// 64 bits (one bit per cycle), then a '-' is sent for a negative value and
// the digits are stepped through, one per character or suppressed leading
// zero, as the output takes them; the width is clamped to 32.
// A two-entry queue in front of the converter takes up to two further items
// meanwhile.
module integer_to_decimal_ascii_unit (
	input  logic       clk,
	input  logic       arst_n,
	i2da_in_if.sink    din,
	i2da_out_if.source dout
);
	import i2da_pkg::*;

	logic f_valid;
	logic f_ready;
	job_t f_job;
	logic b_valid;
	logic b_ready;
	job_t b_job;

	i2da_front u_front (
		.din       (din),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	i2da_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job)
	);

	i2da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.dout      (dout)
	);

endmodule
`default_nettype wire

FILE: tb/integer_to_decimal_ascii_unit_checker.sv
`timescale 1ns / 1ps
module integer_to_decimal_ascii_unit_checker (
	input  logic clk,
	input  logic arst_n,
	i2da_in_if   din,
	i2da_out_if  dout,
	output int   errors,
	output int   pending,
	output int   numbers,
	output int   chars
);
	import i2da_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	text_char_t expected_text[$];
	text_char_t want, got;
	int n_err, n_num, n_chr;

	function automatic void predict_text(input logic [63:0] value, input logic is_signed,
		input logic [5:0] min_width);
		logic [63:0] mask;
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  dig [20];
		int unsigned width, pad, total, ndig, n, k;
		text_char_t  c;
		mask  = {64{1'b1}} >> (64 - VALUE_BITS);
		mag   = value & mask;
		width = (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;
		neg   = is_signed && mag[VALUE_BITS-1];
		if (neg)
			mag = (64'd0 - mag) & mask;
		ndig = 0;
		do begin
			if (ndig < 20) begin
				dig[ndig] = 4'(mag % 64'd10);
				ndig++;
			end
			mag = mag / 64'd10;
		end while (mag != 0);
		pad = width;
		if (neg)
			pad = (pad > 0) ? pad - 1 : 0;
		if (pad < ndig)
			pad = ndig;
		total = pad + (neg ? 1 : 0);
		if (total > MAX_WIDTH)
			total = MAX_WIDTH;
		n = 0;
		if (neg) begin
			c.ch   = CHAR_MINUS;
			c.last = (total == 1);
			expected_text.push_back(c);
			n++;
		end
		for (k = pad; k > 0 && n < total; k--) begin
			c.ch   = 8'(CHAR_ZERO + ((k - 1 < ndig) ? dig[k-1] : 4'd0));
			c.last = (n + 1 == total);
			expected_text.push_back(c);
			n++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_text.delete();
			n_err = 0;
			n_num = 0;
			n_chr = 0;
		end else begin
			if (din.valid && din.ready) begin
				predict_text(din.value, din.is_signed, din.min_width);
				n_num++;
			end
			if (dout.valid && dout.ready) begin
				got.ch   = dout.character;
				got.last = dout.last;
				n_chr++;
				if (expected_text.size() == 0) begin
					if (n_err < 10)
						$display("%0t: unexpected char %h last %0d", $realtime, got.ch,
							got.last);
					n_err++;
				end else begin
					want = expected_text.pop_front();
					if (want != got) begin
						if (n_err < 10)
							$display("%0t: char %0d expected %h last %0d, got %h last %0d",
								$realtime, n_chr, want.ch, want.last, got.ch, got.last);
						n_err++;
					end
				end
			end
		end
		errors  <= n_err;
		pending <= expected_text.size();
		numbers <= n_num;
		chars   <= n_chr;
	end

endmodule

FILE: tb/integer_to_decimal_ascii_unit_tb.sv
`timescale 1ns / 1ps
module integer_to_decimal_ascii_unit_tb;
	import i2da_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_NUMBERS = 260;

	logic clk;
	logic arst_n;
	i2da_in_if  din ();
	i2da_out_if dout ();

	int errors, pending, numbers, chars;
	int idle_cycles;
	int burst_left;
	bit holding;
	int rx_phase, rx_mode;

	integer_to_decimal_ascii_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	integer_to_decimal_ascii_unit_checker text_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.dout    (dout),
		.errors  (errors),
		.pending (pending),
		.numbers (numbers),
		.chars   (chars)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] ten_pow(input int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	task automatic send_number(input logic [63:0] value, input logic is_signed,
		input logic [5:0] min_width);
		din.valid     <= 1'b1;
		din.value     <= value;
		din.is_signed <= is_signed;
		din.min_width <= min_width;
		holding = 1'b1;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			din.valid <= 1'b0;
			holding = 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic drain();
		if (holding) begin
			din.valid <= 1'b0;
			holding = 1'b0;
		end
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver: modes of random length, full rate to heavy backpressure
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode  = $urandom_range(0, 3);
			rx_phase = $urandom_range(20, 120);
		end else begin
			rx_phase--;
		end
		case (rx_mode)
			0: dout.ready <= 1'b1;
			1: dout.ready <= 1'($urandom_range(0, 1));
			2: dout.ready <= ($urandom_range(0, 4) == 0);
			default: dout.ready <= (rx_phase % 4 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((din.valid && din.ready) || (dout.valid && dout.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
				$display("integer_to_decimal_ascii_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] v;
		logic        s;
		logic [5:0]  w;
		din.valid     = 1'b0;
		din.value     = '0;
		din.is_signed = 1'b0;
		din.min_width = '0;
		dout.ready    = 1'b0;
		rx_phase      = 0;
		rx_mode       = 0;
		idle_cycles   = 0;
		burst_left    = 0;
		holding       = 1'b0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, most negative, padding and clamping
		send_number(64'd0, 1'b0, 6'd0);
		send_number(64'd0, 1'b1, 6'd0);
		send_number({64{1'b1}}, 1'b0, 6'd0);
		send_number({64{1'b1}}, 1'b0, 6'd32);
		send_number({64{1'b1}}, 1'b1, 6'd0);
		send_number({64{1'b1}}, 1'b1, 6'd5);
		send_number({1'b1, 63'd0}, 1'b1, 6'd0);
		send_number({1'b1, 63'd0}, 1'b1, 6'd63);
		send_number({1'b1, 63'd0}, 1'b0, 6'd0);
		send_number({1'b0, {63{1'b1}}}, 1'b1, 6'd0);
		send_number(64'd0, 1'b0, 6'd63);
		send_number(64'd7, 1'b0, 6'd33);
		send_number(64'd0 - 64'd5, 1'b1, 6'd1);
		send_number(64'd0 - 64'd7, 1'b1, 6'd0);
		send_number(64'd0 - 64'd123, 1'b1, 6'd32);
		send_number(64'd0 - 64'd123, 1'b1, 6'd2);
		send_number(ten_pow(10), 1'b0, 6'd0);
		send_number(ten_pow(8), 1'b1, 6'd0);
		send_number(ten_pow(8) - 64'd1, 1'b0, 6'd12);
		send_number(ten_pow(10) - 64'd1, 1'b0, 6'd0);
		send_number(64'd9, 1'b0, 6'd0);
		send_number(64'd10, 1'b1, 6'd21);
		send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 6'd42);
		send_number(64'h5555_5555_5555_5555, 1'b1, 6'd21);
		drain();

		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			s = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: v = {$urandom, $urandom};
				1: v = 64'($urandom_range(0, 9999));
				2: v = ten_pow($urandom_range(0, 19)) - 64'd1 + 64'($urandom_range(0, 2));
				3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				4: begin
					v = 64'd0 - 64'($urandom_range(0, 99999));
					s = 1'b1;
				end
				default: case ($urandom_range(0, 3))
					0: v = 64'd0;
					1: v = {64{1'b1}};
					2: v = {1'b1, 63'd0};
					default: v = {1'b0, {63{1'b1}}};
				endcase
			endcase
			w = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 22));
			send_number(v, s, w);
			if (i == RANDOM_NUMBERS / 2)
				drain();
		end
		drain();
		repeat (200) @(posedge clk);

		$display("covered %0d numbers (signed and unsigned, widths 0 to 63) giving %0d chars,",
			numbers, chars);
		$display("under bursty input and varied output backpressure");
		if (errors == 0 && pending == 0)
			$display("integer_to_decimal_ascii_unit_tb passed");
		else
			$display("integer_to_decimal_ascii_unit_tb failed");
		$finish;
	end

endmodule
